[src/cave_automaton_step_defines.svh]
// assertion macros for the cave automaton step block
`ifndef CAVE_AUTOMATON_STEP_DEFINES_SVH
`define CAVE_AUTOMATON_STEP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent holds -> consequent holds in the same cycle
`define CAS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cave automaton step: same-cycle check failed");

// antecedent holds -> consequent holds in the next cycle
`define CAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cave automaton step: next-cycle check failed");

`else

`define CAS_ASSERT_SAME(label, clk, rst, ante, cons)
`define CAS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/cas_pkg.sv]
package cas_pkg;

   // cell kinds
   localparam logic [1:0] KIND_FLOOR = 2'd0;
   localparam logic [1:0] KIND_WALL  = 2'd1;

   // smoothing thresholds
   localparam logic [3:0] FLOOR_TO_WALL = 4'd5;
   localparam logic [3:0] WALL_KEEP     = 4'd4;

   // room size after reset
   localparam int SIZE_RESET = 16;

   // csr register indexes
   localparam logic CSR_ROOM_WIDTH  = 1'b0;
   localparam logic CSR_ROOM_HEIGHT = 1'b1;

   // one column of the 3x3 window: row above two, row above one, current row
   typedef struct packed {
      logic [1:0] top;
      logic [1:0] mid;
      logic [1:0] bot;
   } column_type;

   localparam column_type COL_WALL = '{top: KIND_WALL, mid: KIND_WALL, bot: KIND_WALL};

   // raster position flags of an accepted item
   typedef struct packed {
      logic col_zero;
      logic col_last;
      logic row_ge1;
      logic row_ge2;
      logic row_last;
   } flags_type;

   typedef enum logic [2:0] {
      MODE_RUN,
      MODE_EDGE,
      MODE_DRAIN_LOAD,
      MODE_STEP,
      MODE_TAIL
   } mode_type;

   function automatic logic [3:0] wall_bit(input logic [1:0] kind);
      return (kind == KIND_WALL) ? 4'd1 : 4'd0;
   endfunction

   function automatic logic [3:0] count_walls(input column_type left,
                                              input column_type center,
                                              input column_type right);
      return wall_bit(left.top) + wall_bit(left.mid) + wall_bit(left.bot)
           + wall_bit(center.top) + wall_bit(center.bot)
           + wall_bit(right.top) + wall_bit(right.mid) + wall_bit(right.bot);
   endfunction

   function automatic logic [1:0] next_kind(input logic [1:0] kind, input logic [3:0] count);
      logic [1:0] result;
      case (kind)
         KIND_FLOOR: result = (count >= FLOOR_TO_WALL) ? KIND_WALL : KIND_FLOOR;
         KIND_WALL:  result = (count >= WALL_KEEP) ? KIND_WALL : KIND_FLOOR;
         default:    result = kind;
      endcase
      return result;
   endfunction

endpackage

[src/cave_automaton_step.sv]
// cave smoothing automaton, one generation over a room of up to 16x16 cells
// (MAX_ROOM_SIZE sets the line buffer depth and the largest room)
// req channel: one cell kind per item, raster order, row 0 and column 0 first
// rsp channel: one smoothed cell per item with its column, row, wall count
//   among the eight neighbours (outside counts as wall) and a last-cell flag
// csr channel: index 0 room width, index 1 room height; always ready, write
//   only while idle; any write restarts the room at row 0, column 0
// order: the result for cell (r, c) is loaded as the item for (r+1, c+1)
//   leaves the input register, a right-edge cell in the edge state after
//   the next row's last item; the last row is replayed from the line buffers
//   once the room's final item arrives and ends with last_cell set
// throughput: one item per cycle while rsp_ready does not stall it, set by
//   the single window/result stage; the end of every row after row 0 holds
//   the input for the right-edge result, a room end for the last row replay
// reset: room back to 16x16, position counters and pipeline empty; the line
//   buffers are not cleared since only rows of the current room are read
// stall: with rsp_ready low the result register holds, the window stage waits
//   and req_ready drops once the input register is occupied
module cave_automaton_step #(
   parameter int MAX_ROOM_SIZE = 16
) (
   input  logic       clock,
   input  logic       reset,
   // cell stream in
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cell_kind,
   // smoothed cells out
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_next_kind,
   output logic [3:0] rsp_cell_column,
   output logic [3:0] rsp_cell_row,
   output logic [3:0] rsp_wall_neighbours,
   output logic       rsp_last_cell,
   // room size registers
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [4:0] csr_wdata
);

   localparam int CW = $clog2(MAX_ROOM_SIZE);

   // input register to window stage
   logic               s1_valid;
   logic [1:0]         s1_kind;
   logic [CW-1:0]      s1_col;
   logic [CW-1:0]      s1_row;
   cas_pkg::flags_type s1_flags;
   logic               take;

   // room size as last column / last row index
   logic [CW-1:0]      w_last;
   logic [CW-1:0]      h_last;

   // line buffer port
   logic               buf_we;
   logic [CW-1:0]      buf_addr;
   logic [1:0]         buf_one;
   logic [1:0]         buf_two;

   // position counters, room registers and the input register
   cas_front #(
      .MAX_ROOM_SIZE (MAX_ROOM_SIZE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cell_kind (req_cell_kind),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .take          (take),
      .s1_valid      (s1_valid),
      .s1_kind       (s1_kind),
      .s1_col        (s1_col),
      .s1_row        (s1_row),
      .s1_flags      (s1_flags),
      .w_last        (w_last),
      .h_last        (h_last)
   );

   // two rows of history; one column is rotated per taken item
   cas_lines #(
      .MAX_ROOM_SIZE (MAX_ROOM_SIZE)
   ) u_lines (
      .clock   (clock),
      .wr_en   (buf_we),
      .addr    (buf_addr),
      .wr_kind (s1_kind),
      .rd_one  (buf_one),
      .rd_two  (buf_two)
   );

   // 3x3 window, neighbour count, rule and result register
   cas_core #(
      .MAX_ROOM_SIZE (MAX_ROOM_SIZE)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .s1_valid            (s1_valid),
      .s1_kind             (s1_kind),
      .s1_col              (s1_col),
      .s1_row              (s1_row),
      .s1_flags            (s1_flags),
      .w_last              (w_last),
      .h_last              (h_last),
      .take                (take),
      .buf_we              (buf_we),
      .buf_addr            (buf_addr),
      .buf_one             (buf_one),
      .buf_two             (buf_two),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_next_kind       (rsp_next_kind),
      .rsp_cell_column     (rsp_cell_column),
      .rsp_cell_row        (rsp_cell_row),
      .rsp_wall_neighbours (rsp_wall_neighbours),
      .rsp_last_cell       (rsp_last_cell)
   );

endmodule

[src/cas_front.sv]
module cas_front #(
   parameter int MAX_ROOM_SIZE = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_cell_kind,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [4:0]                         csr_wdata,
   input  logic                               take,
   output logic                               s1_valid,
   output logic [1:0]                         s1_kind,
   output logic [$clog2(MAX_ROOM_SIZE)-1:0]   s1_col,
   output logic [$clog2(MAX_ROOM_SIZE)-1:0]   s1_row,
   output cas_pkg::flags_type                 s1_flags,
   output logic [$clog2(MAX_ROOM_SIZE)-1:0]   w_last,
   output logic [$clog2(MAX_ROOM_SIZE)-1:0]   h_last
);

   localparam int CW = $clog2(MAX_ROOM_SIZE);
   localparam int RESET_SIZE = (cas_pkg::SIZE_RESET > MAX_ROOM_SIZE) ?
                               MAX_ROOM_SIZE : cas_pkg::SIZE_RESET;
   localparam logic [CW-1:0] RESET_LAST = CW'(RESET_SIZE - 1);

   logic [CW-1:0]      w_last_ff, w_last_in;
   logic [CW-1:0]      h_last_ff, h_last_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [CW-1:0]      row_ff, row_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [1:0]         s1_kind_ff;
   logic [CW-1:0]      s1_col_ff;
   logic [CW-1:0]      s1_row_ff;
   cas_pkg::flags_type s1_flags_ff, flags_in;
   logic               accept;

   // zero acts as one, oversize acts as the maximum
   function automatic logic [CW-1:0] size_to_last(input logic [4:0] v);
      logic [CW-1:0] result;
      if (v == 5'd0) begin
         result = '0;
      end else if (int'(v) > MAX_ROOM_SIZE) begin
         result = CW'(MAX_ROOM_SIZE - 1);
      end else begin
         result = CW'(v - 5'd1);
      end
      return result;
   endfunction

   assign csr_ready = 1'b1;
   assign req_ready = !s1_valid_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      flags_in.col_zero = (col_ff == '0);
      flags_in.col_last = (col_ff == w_last_ff);
      flags_in.row_ge1  = (row_ff != '0);
      flags_in.row_ge2  = (row_ff > CW'(1));
      flags_in.row_last = (row_ff == h_last_ff);

      w_last_in   = w_last_ff;
      h_last_in   = h_last_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = s1_valid_ff;

      if (csr_valid) begin
         unique case (csr_index)
            cas_pkg::CSR_ROOM_WIDTH:  w_last_in = size_to_last(csr_wdata);
            cas_pkg::CSR_ROOM_HEIGHT: h_last_in = size_to_last(csr_wdata);
         endcase
         // any write restarts the room
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (flags_in.col_last) begin
            col_in = '0;
            row_in = flags_in.row_last ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff   <= RESET_LAST;
         h_last_ff   <= RESET_LAST;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         w_last_ff   <= w_last_in;
         h_last_ff   <= h_last_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= req_cell_kind;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_flags_ff <= flags_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_kind  = s1_kind_ff;
   assign s1_col   = s1_col_ff;
   assign s1_row   = s1_row_ff;
   assign s1_flags = s1_flags_ff;
   assign w_last   = w_last_ff;
   assign h_last   = h_last_ff;

endmodule

[src/cas_lines.sv]
module cas_lines #(
   parameter int MAX_ROOM_SIZE = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(MAX_ROOM_SIZE)-1:0] addr,
   input  logic [1:0]                       wr_kind,
   output logic [1:0]                       rd_one,
   output logic [1:0]                       rd_two
);

   // row_one holds the row above, row_two the row above that;
   // each write rotates one column down by a row
   logic [1:0] row_one_ff [MAX_ROOM_SIZE];
   logic [1:0] row_two_ff [MAX_ROOM_SIZE];

   assign rd_one = row_one_ff[addr];
   assign rd_two = row_two_ff[addr];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_two_ff[addr] <= row_one_ff[addr];
         row_one_ff[addr] <= wr_kind;
      end
   end

endmodule

[src/cas_core.sv]
`include "cave_automaton_step_defines.svh"

module cas_core #(
   parameter int MAX_ROOM_SIZE = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             s1_valid,
   input  logic [1:0]                       s1_kind,
   input  logic [$clog2(MAX_ROOM_SIZE)-1:0] s1_col,
   input  logic [$clog2(MAX_ROOM_SIZE)-1:0] s1_row,
   input  cas_pkg::flags_type               s1_flags,
   input  logic [$clog2(MAX_ROOM_SIZE)-1:0] w_last,
   input  logic [$clog2(MAX_ROOM_SIZE)-1:0] h_last,
   output logic                             take,
   output logic                             buf_we,
   output logic [$clog2(MAX_ROOM_SIZE)-1:0] buf_addr,
   input  logic [1:0]                       buf_one,
   input  logic [1:0]                       buf_two,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_next_kind,
   output logic [3:0]                       rsp_cell_column,
   output logic [3:0]                       rsp_cell_row,
   output logic [3:0]                       rsp_wall_neighbours,
   output logic                             rsp_last_cell
);

   localparam int CW = $clog2(MAX_ROOM_SIZE);

   cas_pkg::mode_type   mode_ff, mode_in;
   cas_pkg::column_type prev_two_ff, prev_two_in;
   cas_pkg::column_type prev_one_ff, prev_one_in;
   logic [CW-1:0]       d_ff, d_in;
   logic [CW-1:0]       edge_row_ff, edge_row_in;
   logic                pend_ff, pend_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          kind_ff;
   logic [3:0]          col_ff;
   logic [3:0]          row_ff;
   logic [3:0]          count_ff;
   logic                last_ff;

   logic                out_can;
   logic                needs_emit;
   logic                load;
   cas_pkg::column_type run_new;
   cas_pkg::column_type drain_new;
   cas_pkg::column_type em_left, em_center, em_right;
   logic [CW-1:0]       em_col;
   logic [CW-1:0]       em_row;
   logic                em_last;
   logic [3:0]          em_count;
   logic [1:0]          em_kind;

   assign out_can    = !rsp_valid_ff || rsp_ready;
   assign needs_emit = s1_flags.row_ge1 && !s1_flags.col_zero;

   // new window column from the arriving cell and the two buffered rows
   assign run_new.top = s1_flags.row_ge2 ? buf_two : cas_pkg::KIND_WALL;
   assign run_new.mid = buf_one;
   assign run_new.bot = s1_kind;

   // last row replay: nothing below it
   assign drain_new.top = (h_last != '0) ? buf_two : cas_pkg::KIND_WALL;
   assign drain_new.mid = buf_one;
   assign drain_new.bot = cas_pkg::KIND_WALL;

   always_comb begin
      mode_in     = mode_ff;
      prev_two_in = prev_two_ff;
      prev_one_in = prev_one_ff;
      d_in        = d_ff;
      edge_row_in = edge_row_ff;
      pend_in     = pend_ff;
      take        = 1'b0;
      buf_we      = 1'b0;
      buf_addr    = d_ff;
      load        = 1'b0;
      em_left     = prev_two_ff;
      em_center   = prev_one_ff;
      em_right    = cas_pkg::COL_WALL;
      em_col      = w_last;
      em_row      = h_last;
      em_last     = 1'b0;

      unique case (mode_ff)
         cas_pkg::MODE_RUN: begin
            buf_addr = s1_col;
            em_right = run_new;
            em_col   = s1_col - CW'(1);
            em_row   = s1_row - CW'(1);
            if (s1_valid && (!needs_emit || out_can)) begin
               take        = 1'b1;
               buf_we      = 1'b1;
               load        = needs_emit;
               prev_two_in = s1_flags.col_zero ? cas_pkg::COL_WALL : prev_one_ff;
               prev_one_in = run_new;
               edge_row_in = s1_row - CW'(1);
               pend_in     = s1_flags.col_last && s1_flags.row_last;
               d_in        = '0;
               if (s1_flags.col_last && s1_flags.row_ge1) begin
                  mode_in = cas_pkg::MODE_EDGE;
               end else if (s1_flags.col_last && s1_flags.row_last) begin
                  mode_in = cas_pkg::MODE_DRAIN_LOAD;
               end
            end
         end
         cas_pkg::MODE_EDGE: begin
            em_row = edge_row_ff;
            if (out_can) begin
               load    = 1'b1;
               mode_in = pend_ff ? cas_pkg::MODE_DRAIN_LOAD : cas_pkg::MODE_RUN;
            end
         end
         cas_pkg::MODE_DRAIN_LOAD: begin
            prev_two_in = cas_pkg::COL_WALL;
            prev_one_in = drain_new;
            d_in        = d_ff + CW'(1);
            mode_in     = (w_last == '0) ? cas_pkg::MODE_TAIL : cas_pkg::MODE_STEP;
         end
         cas_pkg::MODE_STEP: begin
            em_right = drain_new;
            em_col   = d_ff - CW'(1);
            if (out_can) begin
               load        = 1'b1;
               prev_two_in = prev_one_ff;
               prev_one_in = drain_new;
               if (d_ff == w_last) begin
                  mode_in = cas_pkg::MODE_TAIL;
               end else begin
                  d_in = d_ff + CW'(1);
               end
            end
         end
         cas_pkg::MODE_TAIL: begin
            em_last = 1'b1;
            if (out_can) begin
               load    = 1'b1;
               mode_in = cas_pkg::MODE_RUN;
            end
         end
         default: mode_in = cas_pkg::MODE_RUN;
      endcase
   end

   assign em_count = cas_pkg::count_walls(em_left, em_center, em_right);
   assign em_kind  = cas_pkg::next_kind(em_center.mid, em_count);

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= cas_pkg::MODE_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_two_ff <= prev_two_in;
      prev_one_ff <= prev_one_in;
      d_ff        <= d_in;
      edge_row_ff <= edge_row_in;
      pend_ff     <= pend_in;
      if (load) begin
         kind_ff  <= em_kind;
         col_ff   <= 4'(em_col);
         row_ff   <= 4'(em_row);
         count_ff <= em_count;
         last_ff  <= em_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_kind       = kind_ff;
   assign rsp_cell_column     = col_ff;
   assign rsp_cell_row        = row_ff;
   assign rsp_wall_neighbours = count_ff;
   assign rsp_last_cell       = last_ff;

   // the room's final result always carries the last flag
   `CAS_ASSERT_NEXT(a_tail_sets_last, clock, reset, mode_ff == cas_pkg::MODE_TAIL && out_can, rsp_valid_ff && last_ff)
   // replay of the last row starts with a wall column on the left
   `CAS_ASSERT_NEXT(a_drain_left_wall, clock, reset, mode_ff == cas_pkg::MODE_DRAIN_LOAD, prev_two_ff == cas_pkg::COL_WALL)
   // a replay step never reads column zero
   `CAS_ASSERT_SAME(a_step_column, clock, reset, mode_ff == cas_pkg::MODE_STEP, d_ff != '0)

endmodule
